### src/spcr_pkg.sv
// Shared types, codes and the key position table for the swipe path reducer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package spcr_pkg;

   // One request: a letter byte and the end-of-word mark.
   typedef struct packed {
      logic [7:0] letter_char;
      logic       word_end;
   } req_type;

   // One result handed to the downstream side.
   typedef struct packed {
      logic [3:0] key_column;
      logic [1:0] key_row;
      logic       bad_letter;
      logic       code_end;
      logic       run_last;
   } rsp_type;

   // A key position on the keyboard.
   typedef struct packed {
      logic [1:0] row;
      logic [3:0] col;
   } point_type;

   // One result slot produced by the front end (run_last is added later).
   typedef struct packed {
      logic [3:0] key_column;
      logic [1:0] key_row;
      logic       bad_letter;
      logic       code_end;
   } slot_type;

   // All results caused by one request, oldest in slot 0.
   typedef struct packed {
      logic [1:0]     count;
      slot_type [2:0] slots;
   } cmd_type;

   // Reducer modes, one-hot.
   typedef enum logic [2:0] {
      MODE_EMPTY = 3'b001,
      MODE_ONE   = 3'b010,
      MODE_LINE  = 3'b100
   } mode_type;

   localparam logic [7:0] LETTER_FIRST = 8'h61;
   localparam logic [7:0] LETTER_LAST  = 8'h7a;
   localparam int         QUEUE_DEPTH  = 4;
   localparam int         QPTR_W       = $clog2(QUEUE_DEPTH);

   // QWERTY key position of letter a..z, row in bits 5:4 and column in 3:0.
   function automatic point_type key_pos(input logic [4:0] idx);
      logic [5:0] code;
      unique case (idx)
         5'd0:  code = 6'h10;
         5'd1:  code = 6'h24;
         5'd2:  code = 6'h22;
         5'd3:  code = 6'h12;
         5'd4:  code = 6'h02;
         5'd5:  code = 6'h13;
         5'd6:  code = 6'h14;
         5'd7:  code = 6'h15;
         5'd8:  code = 6'h07;
         5'd9:  code = 6'h16;
         5'd10: code = 6'h17;
         5'd11: code = 6'h18;
         5'd12: code = 6'h26;
         5'd13: code = 6'h25;
         5'd14: code = 6'h08;
         5'd15: code = 6'h09;
         5'd16: code = 6'h00;
         5'd17: code = 6'h03;
         5'd18: code = 6'h11;
         5'd19: code = 6'h04;
         5'd20: code = 6'h06;
         5'd21: code = 6'h23;
         5'd22: code = 6'h01;
         5'd23: code = 6'h21;
         5'd24: code = 6'h05;
         5'd25: code = 6'h20;
         default: code = 6'h00;
      endcase
      return point_type'(code);
   endfunction

endpackage

### src/spcr_front.sv
// Front end: accepts letters, looks up key positions and runs the reducer.
// Emits one command per request that causes results. Depends on spcr_pkg.
`timescale 1ns / 1ps

module spcr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spcr_pkg::req_type req_data,
   input  logic              cmd_full,
   output logic              cmd_push,
   output spcr_pkg::cmd_type cmd_data
);

   spcr_pkg::mode_type  mode_ff, mode_in;
   spcr_pkg::point_type first_ff, first_in;
   spcr_pkg::point_type second_ff, second_in;

   logic                req_accept;
   logic                letter_ok;
   logic [7:0]          letter_off;
   spcr_pkg::point_type pos;
   logic                same_row;
   logic                mono;
   spcr_pkg::cmd_type   cmd;

   assign req_stall  = cmd_full;
   assign req_accept = req_valid && !cmd_full;

   // Classify the byte and look up its key.
   assign letter_ok  = (req_data.letter_char >= spcr_pkg::LETTER_FIRST) &&
                       (req_data.letter_char <= spcr_pkg::LETTER_LAST);
   assign letter_off = req_data.letter_char - spcr_pkg::LETTER_FIRST;
   assign pos        = spcr_pkg::key_pos(letter_off[4:0]);

   // Collinear test of the two held points and the new one.
   assign same_row = (first_ff.row == second_ff.row) && (second_ff.row == pos.row);
   assign mono     = ((first_ff.col <= second_ff.col) && (second_ff.col <= pos.col)) ||
                     ((first_ff.col >= second_ff.col) && (second_ff.col >= pos.col));

   // Reducer step and flush, collecting the results in order.
   always_comb begin
      logic [1:0] n;
      n         = 2'd0;
      mode_in   = mode_ff;
      first_in  = first_ff;
      second_in = second_ff;
      cmd       = '0;
      if (letter_ok) begin
         unique case (mode_ff)
            spcr_pkg::MODE_ONE: begin
               if (pos != first_ff) begin
                  second_in = pos;
                  mode_in   = spcr_pkg::MODE_LINE;
               end
            end
            spcr_pkg::MODE_LINE: begin
               if (!(same_row && mono)) begin
                  cmd.slots[n] = '{key_column: first_ff.col, key_row: first_ff.row,
                                   bad_letter: 1'b0, code_end: 1'b0};
                  n = n + 2'd1;
                  first_in = second_ff;
               end
               second_in = pos;
            end
            default: begin
               first_in = pos;
               mode_in  = spcr_pkg::MODE_ONE;
            end
         endcase
      end else begin
         cmd.slots[n] = '{key_column: 4'd0, key_row: 2'd0, bad_letter: 1'b1,
                          code_end: 1'b0};
         n = n + 2'd1;
      end
      if (req_data.word_end) begin
         unique case (mode_in)
            spcr_pkg::MODE_ONE: begin
               cmd.slots[n] = '{key_column: first_in.col, key_row: first_in.row,
                                bad_letter: 1'b0, code_end: 1'b1};
               n = n + 2'd1;
            end
            spcr_pkg::MODE_LINE: begin
               cmd.slots[n] = '{key_column: first_in.col, key_row: first_in.row,
                                bad_letter: 1'b0, code_end: 1'b0};
               n = n + 2'd1;
               cmd.slots[n] = '{key_column: second_in.col, key_row: second_in.row,
                                bad_letter: 1'b0, code_end: 1'b1};
               n = n + 2'd1;
            end
            default: begin
            end
         endcase
         mode_in = spcr_pkg::MODE_EMPTY;
      end
      cmd.count = n;
   end

   assign cmd_push = req_accept && (cmd.count != 2'd0);
   assign cmd_data = cmd;

   // Reducer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= spcr_pkg::MODE_EMPTY;
         first_ff  <= '0;
         second_ff <= '0;
      end else if (req_accept) begin
         mode_ff   <= mode_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule

### src/spcr_queue.sv
// Short command queue between the front end and the result serializer.
// Holds whole commands; depends on spcr_pkg.
`timescale 1ns / 1ps

module spcr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  spcr_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output spcr_pkg::cmd_type head_data
);

   localparam int CNT_W = spcr_pkg::QPTR_W + 1;

   spcr_pkg::cmd_type                store_ff [spcr_pkg::QUEUE_DEPTH];
   logic [spcr_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [spcr_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                 count_ff, count_in;

   assign full       = (count_ff == CNT_W'(spcr_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = store_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/spcr_back.sv
// Back end: walks the result slots of the head command, one result a cycle
// while not stalled, into a registered output. Depends on spcr_pkg.
`timescale 1ns / 1ps

module spcr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  spcr_pkg::cmd_type head_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spcr_pkg::rsp_type rsp_data
);

   logic [1:0]         sel_ff, sel_in;
   logic               rsp_valid_ff, rsp_valid_in;
   spcr_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   spcr_pkg::slot_type slot;
   logic               last_slot;
   logic               load;

   assign slot      = head_data.slots[sel_ff];
   assign last_slot = (sel_ff == head_data.count - 2'd1);
   assign load      = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop       = load && last_slot;

   // Next output register contents and slot index.
   always_comb begin
      rsp_data_in  = '{key_column: slot.key_column, key_row: slot.key_row,
                       bad_letter: slot.bad_letter, code_end: slot.code_end,
                       run_last: last_slot};
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      sel_in       = sel_ff;
      if (load) begin
         sel_in = last_slot ? 2'd0 : sel_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload holds while stalled.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/swipe_path_row_collinear_reducer_top.sv
// Top level of the swipe path reducer: front end, command queue, back end.
// Depends on spcr_pkg, spcr_front, spcr_queue and spcr_back.
//
// Usage:
// The req channel takes one letter byte per request with word_end marking
// the last letter of a word. The rsp channel returns key positions of the
// reduced path, error results for bytes outside a..z, code_end on the last
// point of a word and run_last on the last result of each request.
// A request causes zero to three results; one with none produces no output.
// A taken request's results pass the command queue and the output register.
// Throughput: one request per cycle while the queue has room; the output
// side delivers one result per cycle unless stalled, so requests with two or
// three results drain at that rate through the four-entry command queue.
// Reset clears the reducer to its empty mode, empties the queue and drops
// the output register; there is no clearing pass.
// When the receiver stalls, the output result holds and the queue fills;
// req_stall rises only when the queue is full.
`timescale 1ns / 1ps

module swipe_path_row_collinear_reducer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spcr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spcr_pkg::rsp_type rsp_data
);

   logic              cmd_push;
   spcr_pkg::cmd_type cmd_data;
   logic              cmd_full;
   logic              cmd_pop;
   logic              head_valid;
   spcr_pkg::cmd_type head_data;

   // Classification and reduction.
   spcr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_data)
   );

   // Decoupling queue.
   spcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_data),
      .full       (cmd_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // Result serializer.
   spcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (cmd_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

### tb/spcr_checker.sv
// Checker for the swipe path reducer: watches both channels, predicts each result
// from accepted requests and compares them in order. Depends on spcr_pkg.
`timescale 1ns / 1ps

module spcr_checker import spcr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      waiting_count,
   output int      results_checked,
   output int      bad_letters_seen
);

   // Private copy of the reducer state.
   mode_type  path_mode = MODE_EMPTY;
   point_type held_first = '0;
   point_type held_second = '0;
   rsp_type   expected_points[$];
   int        failures = 0;
   int        checked = 0;
   int        bad_seen = 0;

   // Finds the key of a lowercase letter by scanning the three keyboard rows.
   function automatic point_type letter_point(input logic [7:0] ch);
      string     keyboard_rows[3] = '{"qwertyuiop", "asdfghjkl", "zxcvbnm"};
      point_type p;
      p = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < keyboard_rows[r].len(); c++) begin
            if (keyboard_rows[r][c] == ch) begin
               p.row = 2'(r);
               p.col = 4'(c);
            end
         end
      end
      return p;
   endfunction

   function automatic rsp_type point_result(input point_type p, input logic end_mark);
      rsp_type res;
      res = '0;
      res.key_column = p.col;
      res.key_row    = p.row;
      res.code_end   = end_mark;
      return res;
   endfunction

   // Works out every result of one request and queues them, oldest first.
   task automatic predict_path(input req_type r);
      rsp_type   batch[$];
      rsp_type   err;
      point_type p;
      logic      flat_row;
      logic      monotonic;
      if (r.letter_char >= LETTER_FIRST && r.letter_char <= LETTER_LAST) begin
         p = letter_point(r.letter_char);
         case (path_mode)
            MODE_ONE: begin
               // A repeat of the lone point is dropped.
               if (p != held_first) begin
                  held_second = p;
                  path_mode   = MODE_LINE;
               end
            end
            MODE_LINE: begin
               // The middle of three monotonic points on one row is dropped.
               flat_row  = held_first.row == held_second.row && held_second.row == p.row;
               monotonic = (held_first.col <= held_second.col && held_second.col <= p.col) ||
                           (held_first.col >= held_second.col && held_second.col >= p.col);
               if (!(flat_row && monotonic)) begin
                  batch = {batch, point_result(held_first, 1'b0)};
                  held_first = held_second;
               end
               held_second = p;
            end
            default: begin
               held_first = p;
               path_mode  = MODE_ONE;
            end
         endcase
      end else begin
         err = '0;
         err.bad_letter = 1'b1;
         batch = {batch, err};
      end
      // End of word flushes whatever is held.
      if (r.word_end) begin
         if (path_mode == MODE_ONE) begin
            batch = {batch, point_result(held_first, 1'b1)};
         end else if (path_mode == MODE_LINE) begin
            batch = {batch, point_result(held_first, 1'b0)};
            batch = {batch, point_result(held_second, 1'b1)};
         end
         path_mode = MODE_EMPTY;
      end
      if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
      foreach (batch[i]) expected_points = {expected_points, batch[i]};
   endtask

   // Predict on accepted requests, compare on accepted results.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         path_mode   = MODE_EMPTY;
         held_first  = '0;
         held_second = '0;
         expected_points.delete();
      end else begin
         if (req_valid && !req_stall) predict_path(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: result with none expected: col %0d row %0d bad %0b %s %0b %0b",
                           $time, rsp_data.key_column, rsp_data.key_row, rsp_data.bad_letter,
                           "end/last", rsp_data.code_end, rsp_data.run_last);
            end else begin
               want = expected_points.pop_front();
               checked++;
               if (rsp_data.bad_letter) bad_seen++;
               if (rsp_data.key_column !== want.key_column ||
                   rsp_data.key_row !== want.key_row ||
                   rsp_data.bad_letter !== want.bad_letter ||
                   rsp_data.code_end !== want.code_end ||
                   rsp_data.run_last !== want.run_last) begin
                  failures++;
                  if (failures <= 10) begin
                     $write("%0t: mismatch: expected col %0d row %0d bad %0b end %0b last %0b,",
                            $time, want.key_column, want.key_row, want.bad_letter,
                            want.code_end, want.run_last);
                     $display(" got col %0d row %0d bad %0b end %0b last %0b",
                              rsp_data.key_column, rsp_data.key_row, rsp_data.bad_letter,
                              rsp_data.code_end, rsp_data.run_last);
                  end
               end
            end
         end
      end
      mismatch_count   <= failures;
      waiting_count    <= expected_points.size();
      results_checked  <= checked;
      bad_letters_seen <= bad_seen;
   end

endmodule

### tb/testbench.sv
// Testbench top for the swipe path reducer: clock, reset, request and stall stimulus
// and the verdict. Depends on spcr_pkg, spcr_checker and the block itself.
`timescale 1ns / 1ps

module testbench;
   import spcr_pkg::*;

   localparam int ITEM_TARGET    = 410;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 80;
   localparam int TX_IDLE[4]     = '{0, 45, 0, 32};
   localparam int RX_STALL[4]    = '{0, 0, 45, 32};

   // Directed words: letter byte and end-of-word mark.
   localparam logic [8:0] DIRECTED_REQS[24] = '{
      {"q", 1'b1},
      {"q", 1'b0}, {"w", 1'b0}, {"e", 1'b0}, {"r", 1'b1},
      {"z", 1'b0}, {"z", 1'b0}, {"m", 1'b1},
      {"p", 1'b0}, {"o", 1'b0}, {"p", 1'b0}, {"a", 1'b1},
      {"a", 1'b0}, {"s", 1'b0}, {8'hff, 1'b1},
      {8'h60, 1'b1}, {8'h7b, 1'b1},
      {8'h00, 1'b0}, {"m", 1'b0}, {8'h41, 1'b0}, {"z", 1'b0}, {"a", 1'b1},
      {"a", 1'b0}, {"a", 1'b1}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int    tx_idle_pct = 0;
   int    rx_stall_pct = 0;
   int    hold_requests = 0;
   int    items_sent = 0;
   int    quiet_cycles = 0;
   int    mismatch_count;
   int    waiting_count;
   int    results_checked;
   int    bad_letters_seen;
   string keyboard_rows[3] = '{"qwertyuiop", "asdfghjkl", "zxcvbnm"};

   always #10 clock = ~clock;

   swipe_path_row_collinear_reducer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   spcr_checker path_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .mismatch_count   (mismatch_count),
      .waiting_count    (waiting_count),
      .results_checked  (results_checked),
      .bad_letters_seen (bad_letters_seen)
   );

   // Receiver: random stalls, plus a long hold each time one is asked for.
   initial begin : receiver
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_stall_pct);
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("swipe_path_row_collinear_reducer_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one request after a random gap and waits until it is taken.
   task automatic send_request(input logic [7:0] ch, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{letter_char: ch, word_end: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // One random word; most letters walk along a row so that runs get merged.
   task automatic send_random_word(input bit noisy);
      int         length;
      int         row;
      int         col;
      int         dir;
      int         choice;
      logic [7:0] ch;
      length = $urandom_range(8, 1);
      row    = $urandom_range(2);
      col    = $urandom_range(keyboard_rows[row].len() - 1);
      dir    = int'($urandom_range(2)) - 1;
      for (int i = 0; i < length; i++) begin
         choice = $urandom_range(99);
         if (noisy && choice < 25) begin
            ch = 8'($urandom_range(255));
         end else begin
            if (i > 0 && choice < 10) begin
               // Same key again.
            end else if (i > 0 && choice < 70) begin
               col = col + dir;
               if (col < 0) col = 0;
               if (col > keyboard_rows[row].len() - 1) col = keyboard_rows[row].len() - 1;
            end else begin
               row = $urandom_range(2);
               col = $urandom_range(keyboard_rows[row].len() - 1);
            end
            ch = keyboard_rows[row][col];
         end
         send_request(ch, i == length - 1);
      end
   endtask

   // Stimulus: directed words, then random words under four idle/stall mixes.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 24; i++) send_request(DIRECTED_REQS[i][8:1], DIRECTED_REQS[i][0]);

      for (int ph = 0; ph < 4; ph++) begin
         tx_idle_pct = TX_IDLE[ph];
         rx_stall_pct <= RX_STALL[ph];
         // Long receiver hold while the sender keeps pushing.
         if (ph == 0) hold_requests <= hold_requests + 1;
         while (items_sent < 24 + (ph + 1) * ITEM_TARGET / 4)
            send_random_word($urandom_range(4) == 0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d requests: directed words, row walks, noisy words and one long hold,",
               items_sent);
      $display("under four sender/receiver idle mixes; %0d results checked, %0d bad-letter reports.",
               results_checked, bad_letters_seen);
      if (mismatch_count == 0 && waiting_count == 0) begin
         $display("swipe_path_row_collinear_reducer_top test passed");
      end else begin
         $display("swipe_path_row_collinear_reducer_top test failed");
      end
      $finish;
   end

endmodule
